// ===== hw/rtl/esr_pkg.sv =====
// Package for the event subscription router.
// Holds the table entry type, the request and status codes and the response record.
// No dependencies.
package esr_pkg;

   localparam logic [1:0] FuncSubscribe   = 2'd0;
   localparam logic [1:0] FuncUnsubscribe = 2'd1;
   localparam logic [1:0] FuncNotify      = 2'd2;
   localparam logic [1:0] FuncClear       = 2'd3;

   localparam logic [2:0] StatusOk         = 3'd0;
   localparam logic [2:0] StatusAlready    = 3'd1;
   localparam logic [2:0] StatusBadDevice  = 3'd2;
   localparam logic [2:0] StatusFull       = 3'd3;
   localparam logic [2:0] StatusNoSubs     = 3'd4;
   localparam logic [2:0] StatusDelivery   = 3'd5;

   localparam int MaxOut      = 32;
   localparam int DelivWidth  = $clog2(MaxOut + 1);
   localparam int MaskWidth   = 16;

   typedef struct packed {
      logic [63:0] ev_key;
      logic [7:0]  subscriber;
      logic [7:0]  trigger;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  target_device;
      logic [63:0] ev_key;
      logic [63:0] event_count;
      logic [63:0] event_timestamp;
      logic        update_valid;
      logic [7:0]  update_device;
      logic        update_flag;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/esr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module esr_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/event_subscription_router_unit.sv =====
// Top level of the event subscription router.
// Depends on esr_pkg and esr_ram.
//
// A request is taken when start is high and busy is low. The routing table sits in one
// RAM read one entry per cycle, so a subscribe, unsubscribe or notify scans every live
// entry before the next request is taken. An unsubscribe that removes an entry below
// the top of the table then compacts the table through the same RAM port. Clear and a
// subscribe naming an absent device answer without a table scan. Each response is
// shown for one cycle on rsp_strobe and must be taken then; notify deliveries stream
// out during the table scan, at most one per cycle, with rsp_last on the final one.
// No clearing pass follows reset.
module event_subscription_router_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int NUM_DEVICES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [63:0] req_event_id,
   input  logic [7:0]         req_trigger_device,
   input  logic [7:0]         req_subscriber_device,
   input  logic signed [63:0] req_event_count,
   input  logic signed [63:0] req_event_timestamp,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_target_device,
   output logic signed [63:0] rsp_out_event_id,
   output logic signed [63:0] rsp_out_event_count,
   output logic signed [63:0] rsp_out_event_timestamp,
   output logic               rsp_update_valid,
   output logic [7:0]         rsp_update_device,
   output logic               rsp_update_flag,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = esr_pkg::DelivWidth;

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StScan  = 2'd1;
   localparam logic [1:0] StShift = 2'd2;

   function automatic esr_pkg::rsp_type mk_rsp(
      input logic [2:0]  status,
      input logic [7:0]  target,
      input logic [63:0] id,
      input logic [63:0] cnt,
      input logic [63:0] ts,
      input logic        uv,
      input logic [7:0]  ud,
      input logic        uf,
      input logic        lst
   );
      esr_pkg::rsp_type r;
      r.status          = status;
      r.target_device   = target;
      r.ev_key          = id;
      r.event_count     = cnt;
      r.event_timestamp = ts;
      r.update_valid    = uv;
      r.update_device   = ud;
      r.update_flag     = uf;
      r.last            = lst;
      return r;
   endfunction

   function automatic logic is_present(input logic [7:0] dev,
                                       input logic [esr_pkg::MaskWidth-1:0] mask);
      logic ok;
      ok = (32'(dev) < NUM_DEVICES) && (32'(dev) < esr_pkg::MaskWidth);
      return ok && mask[dev[3:0]];
   endfunction

   logic [1:0]              state_ff, state_in;
   logic [15:0]             csr_ff;
   logic [CW-1:0]           total_ff, total_in;
   logic [CW-1:0]           issue_ff, issue_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [AW-1:0]           rd_idx_ff, rd_idx_in;
   logic [1:0]              func_ff, func_in;
   logic [63:0]             ev_ff, ev_in;
   logic [7:0]              trig_ff, trig_in;
   logic [7:0]              sub_ff, sub_in;
   logic [63:0]             cnt_ff, cnt_in;
   logic [63:0]             ts_ff, ts_in;
   logic                    match_ff, match_in;
   logic [1:0]              live_ff, live_in;
   logic                    hit_ff, hit_in;
   logic [AW-1:0]           hit_idx_ff, hit_idx_in;
   logic [7:0]              td_ff, td_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [7:0]              pend_sub_ff, pend_sub_in;
   logic [DW-1:0]           deliv_ff, deliv_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   esr_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   esr_pkg::entry_type      ram_wentry;
   logic                    ram_re;
   logic [AW-1:0]           ram_raddr;
   logic [esr_pkg::EntryWidth-1:0] ram_rdata;
   esr_pkg::entry_type      rd_entry;
   logic                    issuing;
   logic                    draining;
   logic                    hit_e;
   logic                    hit_s;

   esr_ram #(
      .WIDTH(esr_pkg::EntryWidth),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wentry),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_entry = esr_pkg::entry_type'(ram_rdata);
   assign hit_e    = (rd_entry.ev_key == ev_ff);
   assign hit_s    = (rd_entry.subscriber == sub_ff);
   assign issuing  = ((state_ff == StScan) || (state_ff == StShift)) && (issue_ff < total_ff);
   assign draining = !issuing && !rd_valid_ff;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      func_in       = func_ff;
      ev_in         = ev_ff;
      trig_in       = trig_ff;
      sub_in        = sub_ff;
      cnt_in        = cnt_ff;
      ts_in         = ts_ff;
      match_in      = match_ff;
      live_in       = live_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      td_in         = td_ff;
      pend_valid_in = pend_valid_ff;
      pend_sub_in   = pend_sub_ff;
      deliv_in      = deliv_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = rd_idx_ff - 1'b1;
      ram_wentry    = rd_entry;
      ram_re        = 1'b0;
      ram_raddr     = issue_ff[AW-1:0];

      if (issuing) begin
         ram_re      = 1'b1;
         rd_valid_in = 1'b1;
         rd_idx_in   = issue_ff[AW-1:0];
         issue_in    = issue_ff + 1'b1;
      end

      case (state_ff)
         StIdle: begin
            if (start) begin
               func_in       = req_func;
               ev_in         = req_event_id;
               trig_in       = req_trigger_device;
               sub_in        = req_subscriber_device;
               cnt_in        = req_event_count;
               ts_in         = req_event_timestamp;
               match_in      = 1'b0;
               live_in       = 2'd0;
               hit_in        = 1'b0;
               pend_valid_in = 1'b0;
               deliv_in      = '0;
               issue_in      = '0;
               case (req_func)
                  esr_pkg::FuncSubscribe: begin
                     if (!is_present(req_trigger_device, csr_ff) ||
                         !is_present(req_subscriber_device, csr_ff)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(esr_pkg::StatusBadDevice, 8'd0, req_event_id,
                                        64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else begin
                        state_in = StScan;
                     end
                  end
                  esr_pkg::FuncUnsubscribe, esr_pkg::FuncNotify: begin
                     state_in = StScan;
                  end
                  default: begin
                     total_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(esr_pkg::StatusOk, 8'd0, req_event_id,
                                     64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                  end
               endcase
            end
         end
         StScan: begin
            if (rd_valid_ff) begin
               case (func_ff)
                  esr_pkg::FuncSubscribe: begin
                     if (hit_e && hit_s) begin
                        match_in = 1'b1;
                     end
                  end
                  esr_pkg::FuncUnsubscribe: begin
                     if (hit_e) begin
                        live_in = (live_ff == 2'd2) ? 2'd2 : live_ff + 2'd1;
                        if (!hit_ff && hit_s) begin
                           hit_in     = 1'b1;
                           hit_idx_in = rd_idx_ff;
                           td_in      = rd_entry.trigger;
                        end
                     end
                  end
                  esr_pkg::FuncNotify: begin
                     if (hit_e && (deliv_ff < DW'(esr_pkg::MaxOut))) begin
                        if (pend_valid_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = mk_rsp(esr_pkg::StatusDelivery, pend_sub_ff, ev_ff,
                                           cnt_ff, ts_ff, 1'b0, 8'd0, 1'b0, 1'b0);
                        end
                        pend_valid_in = 1'b1;
                        pend_sub_in   = rd_entry.subscriber;
                        deliv_in      = deliv_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (draining) begin
               state_in     = StIdle;
               rsp_valid_in = 1'b1;
               case (func_ff)
                  esr_pkg::FuncSubscribe: begin
                     if (match_ff) begin
                        rsp_in = mk_rsp(esr_pkg::StatusAlready, 8'd0, ev_ff,
                                        64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else if (total_ff == CW'(TABLE_DEPTH)) begin
                        rsp_in = mk_rsp(esr_pkg::StatusFull, 8'd0, ev_ff,
                                        64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else begin
                        ram_we                = 1'b1;
                        ram_waddr             = total_ff[AW-1:0];
                        ram_wentry.ev_key     = ev_ff;
                        ram_wentry.subscriber = sub_ff;
                        ram_wentry.trigger    = trig_ff;
                        total_in              = total_ff + 1'b1;
                        rsp_in = mk_rsp(esr_pkg::StatusOk, 8'd0, ev_ff,
                                        64'd0, 64'd0, 1'b1, trig_ff, 1'b1, 1'b1);
                     end
                  end
                  esr_pkg::FuncUnsubscribe: begin
                     if (live_ff == 2'd0) begin
                        rsp_in = mk_rsp(esr_pkg::StatusNoSubs, 8'd0, ev_ff,
                                        64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else if (!hit_ff) begin
                        rsp_in = mk_rsp(esr_pkg::StatusOk, 8'd0, ev_ff,
                                        64'd0, 64'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else if ((CW'(hit_idx_ff) + 1'b1) < total_ff) begin
                        rsp_valid_in = 1'b0;
                        state_in     = StShift;
                        issue_in     = CW'(hit_idx_ff) + 1'b1;
                     end else begin
                        total_in = total_ff - 1'b1;
                        rsp_in = mk_rsp(esr_pkg::StatusOk, 8'd0, ev_ff, 64'd0, 64'd0,
                                        live_ff == 2'd1, (live_ff == 2'd1) ? td_ff : 8'd0,
                                        1'b0, 1'b1);
                     end
                  end
                  default: begin
                     if (pend_valid_ff) begin
                        rsp_in = mk_rsp(esr_pkg::StatusDelivery, pend_sub_ff, ev_ff,
                                        cnt_ff, ts_ff, 1'b0, 8'd0, 1'b0, 1'b1);
                     end else begin
                        rsp_in = mk_rsp(esr_pkg::StatusNoSubs, 8'd0, ev_ff,
                                        cnt_ff, ts_ff, 1'b0, 8'd0, 1'b0, 1'b1);
                     end
                  end
               endcase
            end
         end
         StShift: begin
            if (rd_valid_ff) begin
               ram_we = 1'b1;
            end else if (draining) begin
               state_in     = StIdle;
               total_in     = total_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(esr_pkg::StatusOk, 8'd0, ev_ff, 64'd0, 64'd0,
                               live_ff == 2'd1, (live_ff == 2'd1) ? td_ff : 8'd0,
                               1'b0, 1'b1);
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         csr_ff       <= 16'hFFFF;
         total_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      func_ff       <= func_in;
      ev_ff         <= ev_in;
      trig_ff       <= trig_in;
      sub_ff        <= sub_in;
      cnt_ff        <= cnt_in;
      ts_ff         <= ts_in;
      match_ff      <= match_in;
      live_ff       <= live_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      td_ff         <= td_in;
      pend_valid_ff <= pend_valid_in;
      pend_sub_ff   <= pend_sub_in;
      deliv_ff      <= deliv_in;
      rsp_ff        <= rsp_in;
   end

   assign busy                    = (state_ff != StIdle);
   assign rsp_strobe              = rsp_valid_ff;
   assign rsp_status              = rsp_ff.status;
   assign rsp_target_device       = rsp_ff.target_device;
   assign rsp_out_event_id        = rsp_ff.ev_key;
   assign rsp_out_event_count     = rsp_ff.event_count;
   assign rsp_out_event_timestamp = rsp_ff.event_timestamp;
   assign rsp_update_valid        = rsp_ff.update_valid;
   assign rsp_update_device       = rsp_ff.update_device;
   assign rsp_update_flag         = rsp_ff.update_flag;
   assign rsp_last                = rsp_ff.last;

endmodule
